[src/rlms_pkg.sv]
// Shared constants, codes and types for the RGB LED matrix scan driver.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package rlms_pkg;

    // Matrix geometry limits and field widths
    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int CELL_W    = 3;
    localparam int COLOR_W   = 3;
    localparam int LINE_W    = 8;
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int BEAT_W    = 4;

    // Stream and register port widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Input operation codes (s_tuser)
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Output drive kinds (m_tuser)
    localparam logic KIND_PARALLEL = 1'b0;
    localparam logic KIND_SERIAL   = 1'b1;

    // Register word index
    localparam logic REG_SERIAL_MODE = 1'b0;

    // Line word constants
    localparam logic [LINE_W-1:0] LINES_OFF   = 8'h00;
    localparam logic [LINE_W-1:0] LINES_BLANK = 8'hFF;
    localparam logic [LINE_W-1:0] LINE_LSB    = 8'b0000_0001;

    // Beat indices inside a tick
    localparam logic [BEAT_W-1:0] LAST_SERIAL_DARK   = 4'd7;
    localparam logic [BEAT_W-1:0] LAST_SERIAL_LIT    = 4'd15;
    localparam logic [BEAT_W-1:0] LAST_PARALLEL_DARK = 4'd0;
    localparam logic [BEAT_W-1:0] LAST_PARALLEL_LIT  = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

endpackage

[src/rlms_frame_mem.sv]
// Frame store: 64 colour cells in a synchronous memory, one write and one read port.
// Per-entry valid flops make unwritten cells read as off. Depends on rlms_pkg.
`timescale 1ns / 1ps

module rlms_frame_mem
    import rlms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_req_t           req,
    output logic [COLOR_W-1:0] rd_color
);

    logic [COLOR_W-1:0]   mem [MEM_DEPTH];
    logic [COLOR_W-1:0]   rd_mem_reg;
    logic                 rd_valid_reg;
    logic [MEM_DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_mem_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    // An entry never written reads as off
    assign rd_color = rd_valid_reg ? rd_mem_reg : '0;

endmodule

[src/rlms_cfg.sv]
// APB-style register block holding the serial_mode bit.
// Depends on rlms_pkg.
`timescale 1ns / 1ps

module rlms_cfg
    import rlms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic              serial_mode
);

    logic serial_mode_reg;
    logic serial_mode_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        serial_mode_next = serial_mode_reg;
        if (wr_en && (paddr[2] == REG_SERIAL_MODE))
        begin
            serial_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_mode_reg <= 1'b1;
        end
        else
        begin
            serial_mode_reg <= serial_mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SERIAL_MODE)
        begin
            prdata[0] = serial_mode_reg;
        end
    end

    assign serial_mode = serial_mode_reg;

endmodule

[src/rlms_seq.sv]
// Scan sequencer: takes write and tick beats, keeps the scan position, reads the
// frame store and emits the drive beats through an output register. Depends on rlms_pkg.
`timescale 1ns / 1ps

module rlms_seq
    import rlms_pkg::*;
#(
    parameter int ROWS = MAX_ROWS,
    parameter int COLS = MAX_COLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 serial_mode,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    output mem_req_t             mem_req,
    input  logic [COLOR_W-1:0]   rd_color
);

    localparam logic [CELL_W-1:0] LAST_ROW = CELL_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] LAST_COL = CELL_W'(COLS - 1);

    seq_state_t state_reg, state_next;

    logic [CELL_W-1:0]    scan_row_reg, scan_row_next;
    logic [CELL_W-1:0]    scan_col_reg, scan_col_next;
    logic                 serial_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [BEAT_W-1:0]    beat_reg, beat_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    logic [CELL_W-1:0]  w_row, w_col;
    logic [COLOR_W-1:0] w_color;
    logic               accept, accept_tick, in_range, load_beat, out_free;
    logic [CELL_W-1:0]  adv_row, adv_col;

    logic [LINE_W-1:0]  row_bit, col_bit, red_w, grn_w, blu_w;
    logic [LINE_W-1:0]  row_o, red_o, grn_o, blu_o;
    logic [LINE_W-1:0]  row_g, red_g, grn_g, blu_g;
    logic [CELL_W-1:0]  bit_sel;
    logic               latch_o, lit;
    logic [BEAT_W-1:0]  last_idx;

    // Input fields, lowest first: cell_row, cell_col, cell_color
    assign w_row   = s_tdata[2:0];
    assign w_col   = s_tdata[5:3];
    assign w_color = s_tdata[8:6];

    assign accept      = s_tvalid && s_tready;
    assign accept_tick = accept && (s_tuser == OP_TICK);
    assign in_range    = ({1'b0, w_row} < (CELL_W + 1)'(ROWS))
                      && ({1'b0, w_col} < (CELL_W + 1)'(COLS));
    assign out_free    = !m_tvalid_reg || m_tready;

    // Step the scan one cell along the row, wrapping to the next row
    always_comb
    begin
        adv_col = scan_col_reg + 1'b1;
        adv_row = scan_row_reg;
        if (scan_col_reg == LAST_COL)
        begin
            adv_col = '0;
            adv_row = (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + 1'b1;
        end
    end

    // Beat contents
    always_comb
    begin
        lit     = (color_reg != '0);
        row_bit = LINE_LSB << scan_row_reg;
        col_bit = LINE_LSB << scan_col_reg;
        red_w   = color_reg[0] ? col_bit : LINES_OFF;
        grn_w   = color_reg[1] ? col_bit : LINES_OFF;
        blu_w   = color_reg[2] ? col_bit : LINES_OFF;
        bit_sel = ~beat_reg[2:0];
        row_g   = LINES_BLANK;
        red_g   = LINES_BLANK;
        grn_g   = LINES_BLANK;
        blu_g   = LINES_BLANK;
        row_o   = LINES_OFF;
        red_o   = LINES_OFF;
        grn_o   = LINES_OFF;
        blu_o   = LINES_OFF;
        latch_o = 1'b0;
        if (serial_reg)
        begin
            // Second group carries the active-low drive words
            if (beat_reg[3])
            begin
                row_g = ~row_bit;
                red_g = ~red_w;
                grn_g = ~grn_w;
                blu_g = ~blu_w;
            end
            row_o[0] = row_g[bit_sel];
            red_o[0] = red_g[bit_sel];
            grn_o[0] = grn_g[bit_sel];
            blu_o[0] = blu_g[bit_sel];
            latch_o  = (beat_reg[2:0] == 3'd7);
            last_idx = lit ? LAST_SERIAL_LIT : LAST_SERIAL_DARK;
        end
        else
        begin
            if (beat_reg[0])
            begin
                row_o = row_bit;
                red_o = red_w;
                grn_o = grn_w;
                blu_o = blu_w;
            end
            last_idx = lit ? LAST_PARALLEL_LIT : LAST_PARALLEL_DARK;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_tick)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && (beat_reg == last_idx))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready      = 1'b0;
        load_beat     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = {w_row, w_col};
        mem_req.wdata = w_color;
        mem_req.re    = 1'b0;
        mem_req.raddr = {adv_row, adv_col};
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                mem_req.we = accept && (s_tuser == OP_WRITE) && in_range;
                mem_req.re = accept_tick;
            end
            ST_READ:
            begin
            end
            ST_EMIT:
            begin
                load_beat = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        if (accept_tick)
        begin
            scan_row_next = adv_row;
            scan_col_next = adv_col;
        end
        beat_next = beat_reg;
        if (state_reg == ST_READ)
        begin
            beat_next = '0;
        end
        else if (load_beat)
        begin
            beat_next = beat_reg + 1'b1;
        end
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (load_beat)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_row_reg <= LAST_ROW;
            scan_col_reg <= LAST_COL;
            beat_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
            beat_reg     <= beat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_tick)
        begin
            serial_reg <= serial_mode;
        end
        if (state_reg == ST_READ)
        begin
            color_reg <= rd_color;
        end
        if (load_beat)
        begin
            m_tdata_reg <= {7'd0, latch_o, blu_o, grn_o, red_o, row_o};
            m_tuser_reg <= serial_reg ? KIND_SERIAL : KIND_PARALLEL;
            m_tlast_reg <= (beat_reg == last_idx);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[src/rgb_led_matrix_scan_driver.sv]
// Top level of the RGB LED matrix scan driver: register block, sequencer and frame store.
// Depends on rlms_pkg, rlms_cfg, rlms_seq and rlms_frame_mem.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------------
//  s_*      | in  | s_tvalid / s_tready  | tuser: operation; tdata: cell_row, cell_col,
//           |     |                      |        cell_color
//  m_*      | out | m_tvalid / m_tready  | tuser: drive_kind; tlast: last; tdata: row,
//           |     |                      |        red, green, blue lines, latch
//  APB      | in  | psel / penable       | reg 0 serial_mode at address 0
//
// A write beat is taken while the sequencer is idle. A tick is accepted, then the frame
// store is read, then its result beats leave through the output register (8 or 16
// serial, 1 or 2 parallel); a lit cell gives the larger number of beats.
// Reset clears the per-cell valid flops at once, so no clearing pass is needed.
// A stalled m_tready holds the result beat and the sequencer; s_tready is high only
// while no tick is in flight.
`timescale 1ns / 1ps

module rgb_led_matrix_scan_driver
    import rlms_pkg::*;
#(
    parameter int ROWS = MAX_ROWS,
    parameter int COLS = MAX_COLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [2:0] cell_row, [5:3] cell_col, [8:6] cell_color
    input  logic                 s_tuser,  // [0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [7:0] row, [15:8] red, [23:16] green,
                                           // [31:24] blue, [32] latch
    output logic                 m_tuser,  // [0] drive_kind
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic               serial_mode;
    mem_req_t           mem_req;
    logic [COLOR_W-1:0] rd_color;

    rlms_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .serial_mode (serial_mode)
    );

    rlms_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .serial_mode (serial_mode),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mem_req     (mem_req),
        .rd_color    (rd_color)
    );

    rlms_frame_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_color (rd_color)
    );

endmodule

[src/rlms_checker.sv]
// Port-level checks on the result stream of the scan driver, bound to the top level.
// Depends on rlms_pkg and rgb_led_matrix_scan_driver.
`timescale 1ns / 1ps

module rlms_checker
    import rlms_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_latch_serial_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tuser == KIND_SERIAL)
        else $error("latch set on a parallel beat");

    a_serial_single_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SERIAL) |->
            m_tdata[7:1] == 7'd0 && m_tdata[15:9] == 7'd0
            && m_tdata[23:17] == 7'd0 && m_tdata[31:25] == 7'd0)
        else $error("serial beat carries more than one bit per line");

    a_serial_last_latched: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && (m_tuser == KIND_SERIAL) |-> m_tdata[32])
        else $error("serial tick ended inside a shift group");

endmodule

bind rgb_led_matrix_scan_driver rlms_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
